/* hw/rtl/htfc_pkg.sv */
// Shared constants for the humidity/temperature frame converter.
package htfc_pkg;

   // Field widths of one frame and one result
   localparam int ByteWidth  = 8;
   localparam int RawWidth   = 16;
   localparam int ValueWidth = 9;

   // Selector codes for a temperature or a humidity frame
   localparam logic ActTemperature = 1'b0;
   localparam logic ActHumidity    = 1'b1;

   // CRC-8 generator x^8+x^5+x^4+1, low eight bits
   localparam logic [ByteWidth-1:0] CrcPoly = 8'h31;

   // Status bits of the raw reading are cleared before scaling
   localparam logic [RawWidth-1:0] StatusMask = 16'hfffc;

   // Fixed-point scaling: t = floor(mul * r / 2^FracShift) - offset
   localparam int MulWidth    = 15;
   localparam int FracShift   = 13;
   localparam int ProdWidth   = RawWidth + MulWidth;
   localparam int ScaledWidth = ProdWidth - FracShift;
   localparam int MilliWidth  = ScaledWidth + 1;

   localparam logic [MulWidth-1:0] TempMul = 15'd21965;
   localparam logic [MulWidth-1:0] HumMul  = 15'd15625;
   localparam logic signed [MilliWidth-1:0] TempOffset = 19'sd46850;
   localparam logic signed [MilliWidth-1:0] HumOffset  = 19'sd6000;

   // Rounding division by 1000 through a reciprocal multiply
   localparam int MagWidth    = 17;
   localparam int Milli       = 1000;
   localparam logic [MagWidth-1:0] HalfMilli = MagWidth'(Milli / 2);
   localparam int RecipShift  = 27;
   localparam int RecipWidth  = 18;
   localparam logic [RecipWidth-1:0] RecipMul =
      RecipWidth'((2 ** RecipShift + Milli - 1) / Milli);
   localparam int QuotWidth   = ValueWidth - 1;
   localparam int Prod2Width  = RecipShift + QuotWidth;

endpackage

/* hw/rtl/htfc_chan_if.sv */
// Valid/ready channel interfaces for frames and results.
interface htfc_req_if
   import htfc_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic                 action;
   logic [ByteWidth-1:0] data_high;
   logic [ByteWidth-1:0] data_low;
   logic [ByteWidth-1:0] check_byte;

   modport source (output valid, output action, output data_high, output data_low,
                   output check_byte, input ready);
   modport sink   (input valid, input action, input data_high, input data_low,
                   input check_byte, output ready);
endinterface

interface htfc_rsp_if
   import htfc_pkg::*;
   ();
   logic                         valid;
   logic                         ready;
   logic                         check_ok;
   logic signed [ValueWidth-1:0] value;

   modport source (output valid, output check_ok, output value, input ready);
   modport sink   (input valid, input check_ok, input value, output ready);
endinterface

/* hw/rtl/htfc_crc_check.sv */
// CRC-8 check of a three-byte sensor frame.
module htfc_crc_check
   import htfc_pkg::*;
(
   input  logic [ByteWidth-1:0] data_high,
   input  logic [ByteWidth-1:0] data_low,
   input  logic [ByteWidth-1:0] check_byte,
   output logic                 check_ok
);

   // Shift one byte through the generator, MSB first
   function automatic logic [ByteWidth-1:0] crc_byte_step(input logic [ByteWidth-1:0] x);
      logic [ByteWidth-1:0] r;
      r = x;
      for (int i = 0; i < ByteWidth; i++) begin
         if (r[ByteWidth-1]) begin
            r = (r << 1) ^ CrcPoly;
         end else begin
            r = r << 1;
         end
      end
      return r;
   endfunction

   logic [ByteWidth-1:0] crc_high;
   logic [ByteWidth-1:0] crc_full;

   // Zero initial value: first byte enters directly, second folds in
   assign crc_high = crc_byte_step(data_high);
   assign crc_full = crc_byte_step(crc_high ^ data_low);
   assign check_ok = (crc_full == check_byte);

endmodule

/* hw/rtl/humidity_temperature_frame_convert.sv */
// Top level: checks and scales sensor frames into rounded readings.
//
//   channel   direction  payload                                   transfer
//   req_chan  in         action, data_high, data_low, check_byte   valid & ready
//   rsp_chan  out        check_ok, value                           valid & ready
//
// One frame enters per cycle while req_chan.ready is high; a result passes through
// the input register, the scaled reading, the rounded quotient and the result register
// before it can transfer out.
// Reset clears the stage valid bits only; no result is pending after reset.
// A stall on rsp_chan fills the stages one by one; req_chan.ready drops only
// when every stage holds an item, so the block keeps taking frames meanwhile.
module humidity_temperature_frame_convert
   import htfc_pkg::*;
(
   input  logic clock,
   input  logic reset,
   htfc_req_if.sink   req_chan,
   htfc_rsp_if.source rsp_chan
);

   // Stage valid bits
   logic in_valid_ff,  in_valid_in;
   logic t_valid_ff,   t_valid_in;
   logic q_valid_ff,   q_valid_in;
   logic out_valid_ff, out_valid_in;

   // Stage load enables
   logic in_take, t_take, q_take, out_take;

   // Input register
   logic                 in_action_ff;
   logic [ByteWidth-1:0] in_high_ff;
   logic [ByteWidth-1:0] in_low_ff;
   logic [ByteWidth-1:0] in_check_ff;

   // Scaled reading stage
   logic                          t_ok_ff,  t_ok_in;
   logic signed [MilliWidth-1:0]  t_ff,     t_in;

   // Rounded quotient stage
   logic                 q_ok_ff,  q_ok_in;
   logic                 q_neg_ff, q_neg_in;
   logic [QuotWidth-1:0] q_ff,     q_in;

   // Result register
   logic                         out_ok_ff,    out_ok_in;
   logic signed [ValueWidth-1:0] out_value_ff, out_value_in;

   // Scaling datapath signals
   logic [RawWidth-1:0]          raw_masked;
   logic [MulWidth-1:0]          scale_mul;
   logic signed [MilliWidth-1:0] scale_offset;
   logic [ProdWidth-1:0]         scale_prod;
   logic [ScaledWidth-1:0]       scaled;
   logic                         crc_ok;

   // Rounding datapath signals
   logic                  t_neg;
   logic [MilliWidth-1:0] t_mag;
   logic [MagWidth-1:0]   round_num;
   logic [Prod2Width-1:0] recip_prod;
   logic [ValueWidth-1:0] q_ext;

   // Advance a stage when it is empty or its successor advances
   assign out_take = !out_valid_ff || rsp_chan.ready;
   assign q_take   = !q_valid_ff   || out_take;
   assign t_take   = !t_valid_ff   || q_take;
   assign in_take  = !in_valid_ff  || t_take;

   assign req_chan.ready = in_take;

   assign in_valid_in  = req_chan.valid;
   assign t_valid_in   = in_valid_ff;
   assign q_valid_in   = t_valid_ff;
   assign out_valid_in = q_valid_ff;

   // Frame check
   htfc_crc_check u_crc (
      .data_high  (in_high_ff),
      .data_low   (in_low_ff),
      .check_byte (in_check_ff),
      .check_ok   (crc_ok)
   );

   // Mask status bits, scale to milli-units and remove the offset
   always_comb begin
      raw_masked = {in_high_ff, in_low_ff} & StatusMask;
      if (in_action_ff == ActHumidity) begin
         scale_mul    = HumMul;
         scale_offset = HumOffset;
      end else begin
         scale_mul    = TempMul;
         scale_offset = TempOffset;
      end
      scale_prod = ProdWidth'(raw_masked) * ProdWidth'(scale_mul);
      scaled     = scale_prod[FracShift +: ScaledWidth];
      t_in       = $signed({1'b0, scaled}) - scale_offset;
      t_ok_in    = crc_ok;
   end

   // Round half away from zero: divide magnitude plus one half by 1000
   always_comb begin
      t_neg      = t_ff[MilliWidth-1];
      t_mag      = t_neg ? MilliWidth'(-t_ff) : MilliWidth'(t_ff);
      round_num  = t_mag[MagWidth-1:0] + HalfMilli;
      recip_prod = Prod2Width'(round_num) * Prod2Width'(RecipMul);
      q_in       = recip_prod[RecipShift +: QuotWidth];
      q_neg_in   = t_neg;
      q_ok_in    = t_ok_ff;
   end

   // Restore the sign; a failed check reports zero
   always_comb begin
      q_ext     = {1'b0, q_ff};
      out_ok_in = q_ok_ff;
      if (!q_ok_ff) begin
         out_value_in = '0;
      end else if (q_neg_ff) begin
         out_value_in = $signed(-q_ext);
      end else begin
         out_value_in = $signed(q_ext);
      end
   end

   // Stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         t_valid_ff   <= 1'b0;
         q_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_take)  in_valid_ff  <= in_valid_in;
         if (t_take)   t_valid_ff   <= t_valid_in;
         if (q_take)   q_valid_ff   <= q_valid_in;
         if (out_take) out_valid_ff <= out_valid_in;
      end
   end

   // Stage payloads: load on advance, hold otherwise
   always_ff @(posedge clock) begin
      if (in_take) begin
         in_action_ff <= req_chan.action;
         in_high_ff   <= req_chan.data_high;
         in_low_ff    <= req_chan.data_low;
         in_check_ff  <= req_chan.check_byte;
      end
      if (t_take) begin
         t_ok_ff <= t_ok_in;
         t_ff    <= t_in;
      end
      if (q_take) begin
         q_ok_ff  <= q_ok_in;
         q_neg_ff <= q_neg_in;
         q_ff     <= q_in;
      end
      if (out_take) begin
         out_ok_ff    <= out_ok_in;
         out_value_ff <= out_value_in;
      end
   end

   assign rsp_chan.valid    = out_valid_ff;
   assign rsp_chan.check_ok = out_ok_ff;
   assign rsp_chan.value    = out_value_ff;

endmodule

/* hw/rtl/htfc_checker.sv */
// Port-level assertions for the frame converter, bound to the top level.
module htfc_checker
   import htfc_pkg::*;
(
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_check_ok,
   input logic signed [ValueWidth-1:0] rsp_value
);

   localparam int PipeDepth  = 4;
   localparam int CountWidth = 3;

   logic                  req_xfer, rsp_xfer;
   logic [CountWidth-1:0] count_ff, count_in;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   // Track items taken in but not yet delivered
   always_comb begin
      count_in = count_ff;
      if (req_xfer && !rsp_xfer) begin
         count_in = count_ff + 1'b1;
      end else if (!req_xfer && rsp_xfer) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // No result without an outstanding frame, and never more than the stages hold
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid |-> count_ff != '0) && (count_ff <= CountWidth'(PipeDepth)))
      else $error("result without outstanding frame or occupancy overflow");

   // An empty block takes a frame
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> req_ready)
      else $error("empty block refuses a frame");

   // A failed check carries a zero value
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_check_ok |-> rsp_value == '0)
      else $error("failed check with nonzero value");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_check_ok) && $stable(rsp_value))
      else $error("stalled result changed");

   // Nothing pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind humidity_temperature_frame_convert htfc_checker u_htfc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_check_ok (rsp_chan.check_ok),
   .rsp_value    (rsp_chan.value)
);

/* verif/htfc_frame_checker.sv */
// Scoreboard that predicts and checks every reading of the frame converter.
`timescale 1ns / 100ps
module htfc_frame_checker
   import htfc_pkg::*;
(
   input  logic clock,
   input  logic reset,
   htfc_req_if  req_mon,
   htfc_rsp_if  rsp_mon,
   output int   pending,
   output int   fail_count
);

   typedef struct packed {
      logic                         check_ok;
      logic signed [ValueWidth-1:0] value;
   } reading_type;

   reading_type expected_readings[$];

   // Divide the whole frame by the generator; an intact frame leaves no remainder
   function automatic logic frame_intact(logic [RawWidth-1:0] raw,
                                         logic [ByteWidth-1:0] chk);
      logic [RawWidth+ByteWidth-1:0] remainder;
      remainder = {raw, chk};
      for (int i = RawWidth + ByteWidth - 1; i >= ByteWidth; i--) begin
         if (remainder[i]) begin
            remainder[i -: ByteWidth+1] = remainder[i -: ByteWidth+1] ^ {1'b1, CrcPoly};
         end
      end
      return remainder == '0;
   endfunction

   // Scale the masked reading to milli-units, then round to whole units
   function automatic reading_type convert_frame(logic act, logic [RawWidth-1:0] raw,
                                                 logic [ByteWidth-1:0] chk);
      reading_type reading;
      longint      masked;
      int          milli;
      int          whole;
      reading = '0;
      reading.check_ok = frame_intact(raw, chk);
      if (reading.check_ok) begin
         masked = longint'(raw & StatusMask);
         if (act == ActHumidity) begin
            milli = int'((masked * HumMul) >> FracShift) - int'(HumOffset);
         end else begin
            milli = int'((masked * TempMul) >> FracShift) - int'(TempOffset);
         end
         // Ties round away from zero
         if (milli >= 0) begin
            whole = (milli + Milli / 2) / Milli;
         end else begin
            whole = -((Milli / 2 - milli) / Milli);
         end
         reading.value = ValueWidth'(whole);
      end
      return reading;
   endfunction

   always @(posedge clock) begin
      reading_type got;
      reading_type want;
      int          errors;
      errors = 0;
      if (!reset) begin
         // Compare each result transfer with the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.check_ok = rsp_mon.check_ok;
            got.value    = rsp_mon.value;
            if (expected_readings.size() == 0) begin
               $display("%0t: reading with none expected: check_ok=%0b value=%0d",
                        $time, got.check_ok, got.value);
               errors++;
            end else begin
               want = expected_readings.pop_front();
               if (got.check_ok !== want.check_ok) begin
                  $display("%0t: check_ok mismatch: expected %0b, actual %0b",
                           $time, want.check_ok, got.check_ok);
                  errors++;
               end
               if (got.value !== want.value) begin
                  $display("%0t: value mismatch: expected %0d, actual %0d",
                           $time, want.value, got.value);
                  errors++;
               end
            end
         end
         // Predict the reading of each accepted frame
         if (req_mon.valid && req_mon.ready) begin
            expected_readings.push_back(convert_frame(req_mon.action,
                                                      {req_mon.data_high, req_mon.data_low},
                                                      req_mon.check_byte));
         end
      end
      pending    <= expected_readings.size();
      fail_count <= fail_count + errors;
   end

endmodule

/* verif/tb.sv */
// Top of the frame converter testbench: clock, reset, frame stimulus, verdict.
`timescale 1ns / 100ps
module tb;
   import htfc_pkg::*;

   localparam int RandomFrames = 1350;
   localparam int IdlePercent  = 21;

   logic clock = 1'b0;
   logic reset;
   logic steady;
   int   pending;
   int   fail_count;

   htfc_req_if req_chan ();
   htfc_rsp_if rsp_chan ();

   humidity_temperature_frame_convert u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   htfc_frame_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .pending    (pending),
      .fail_count (fail_count)
   );

   always #1 clock = ~clock;

   // Generate the check byte of a well-formed frame
   function automatic logic [ByteWidth-1:0] frame_crc(logic [RawWidth-1:0] raw);
      logic [ByteWidth-1:0] crc;
      crc = '0;
      for (int i = RawWidth - 1; i >= 0; i--) begin
         if (crc[ByteWidth-1] ^ raw[i]) begin
            crc = (crc << 1) ^ CrcPoly;
         end else begin
            crc = crc << 1;
         end
      end
      return crc;
   endfunction

   // Offer one frame after a random gap; return at the edge of its transfer
   task automatic send_frame(logic act, logic [RawWidth-1:0] raw,
                             logic [ByteWidth-1:0] chk);
      while (!steady && $urandom_range(99) < IdlePercent) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.action     <= act;
      req_chan.data_high  <= raw[RawWidth-1:ByteWidth];
      req_chan.data_low   <= raw[ByteWidth-1:0];
      req_chan.check_byte <= chk;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Hold off new frames until every reading has come back
   task automatic drain_readings();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // Stall the result side at random, except during the steady stretch
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= steady || ($urandom_range(99) >= IdlePercent);
      end
   end

   initial begin
      #200000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      logic [RawWidth-1:0]           raw;
      logic [ByteWidth-1:0]          chk;
      logic [RawWidth+ByteWidth-1:0] frame;
      logic [RawWidth-1:0]           corner_raws[9];
      int                            kind;
      corner_raws = '{16'h0000, 16'h0003, 16'hfffc, 16'hffff, 16'h8000,
                      16'h4441, 16'h0c48, 16'h5555, 16'haaaa};
      steady              = 1'b0;
      reset              <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.action     <= ActTemperature;
      req_chan.data_high  <= '0;
      req_chan.data_low   <= '0;
      req_chan.check_byte <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: range ends, status bits, zero crossings, both selectors
      for (int a = 0; a < 2; a++) begin
         foreach (corner_raws[i]) begin
            send_frame((a == 0) ? ActTemperature : ActHumidity, corner_raws[i],
                       frame_crc(corner_raws[i]));
         end
      end
      // Directed: corrupted check bytes and data
      send_frame(ActTemperature, 16'hffff, frame_crc(16'hffff) ^ 8'h80);
      send_frame(ActHumidity, 16'h0000, 8'hff);
      send_frame(ActHumidity, 16'h1234, frame_crc(16'h1234) ^ 8'h01);
      send_frame(ActTemperature, 16'h8000 ^ 16'h0001, frame_crc(16'h8000));

      // Random: mostly intact frames, mixed with random-check-byte and single-bit-error frames
      for (int n = 0; n < RandomFrames; n++) begin
         steady = (n >= 400 && n < 700);
         if (n == 900) begin
            drain_readings();
         end
         raw  = RawWidth'($urandom);
         kind = $urandom_range(99);
         if (kind < 75) begin
            chk = frame_crc(raw);
         end else if (kind < 90) begin
            chk = ByteWidth'($urandom);
         end else begin
            frame = {raw, frame_crc(raw)} ^ ((RawWidth+ByteWidth)'(1) << $urandom_range(23));
            raw   = frame[RawWidth+ByteWidth-1:ByteWidth];
            chk   = frame[ByteWidth-1:0];
         end
         send_frame(1'($urandom), raw, chk);
      end
      steady = 1'b0;

      // Flush the pipeline and give the verdict
      drain_readings();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

/* files.f */
hw/rtl/htfc_pkg.sv
hw/rtl/htfc_chan_if.sv
hw/rtl/htfc_crc_check.sv
hw/rtl/humidity_temperature_frame_convert.sv
hw/rtl/htfc_checker.sv
verif/htfc_frame_checker.sv
verif/tb.sv
